/* design/tsl_pkg.sv */
`timescale 1ns / 1ps

package tsl_pkg;

  // Line geometry
  localparam int MAX_COLS  = 1024;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LEN_RESET = (MAX_COLS < 1024) ? MAX_COLS : 1024;

  // Field and register widths
  localparam int SAMPLE_W    = 32;
  localparam int ROW_W       = 16;
  localparam int PIX_COL_W   = 10;
  localparam int LABEL_W     = 2;
  localparam int RL_W        = 11;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int ROWS_RESET  = 1024;
  localparam int OUT_DATA_W  = 32;

  // Queue between classifier and emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_ROWS = 2'd2;

  typedef enum logic [LABEL_W-1:0] {
    LABEL_BACKGROUND = 2'd0,
    LABEL_INTERIOR   = 2'd1,
    LABEL_SURFACE    = 2'd2
  } label_t;

  // One classified input: up to three labels, in release order
  //   slot 0: voxel one row up, slot 1: voxel to the left, slot 2: this voxel
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [2:0]       mask;
    label_t           lab0;
    label_t           lab1;
    label_t           lab2;
  } job_t;

endpackage

/* design/tsl_front.sv */
`timescale 1ns / 1ps

module tsl_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tsl_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [tsl_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic [tsl_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          in_ready,
  output logic                          job_push,
  output tsl_pkg::job_t                 job,
  input  logic                          job_room
);
  import tsl_pkg::*;

  logic [SAMPLE_W-1:0] threshold;
  logic [COL_W-1:0]    len_m1;
  logic [ROW_W-1:0]    rows_m1;
  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;

  // Per column: {fg two rows up, fg one row up}
  logic [1:0]          mem [MAX_COLS];
  logic [1:0]          rd_a;
  logic [1:0]          rd_b;
  logic                up_left;
  logic                cur_left;
  logic                cur_left2;

  logic                accept;
  logic                geo_write;
  logic                fg;
  logic [COL_W-1:0]    col_next;
  logic [COL_W-1:0]    addr_b;
  logic [COL_W-1:0]    len_m1_next;
  logic [RL_W-1:0]     rl;
  logic [ROW_W-1:0]    sr;
  logic [1:0]          wr_data;
  logic                row_gt0;
  logic                last_row;
  logic                col_gt0;
  logic                col_gt1;
  logic                col_last;
  logic                up_c;
  logic                upup_c;
  logic                up_right;

  assign in_ready  = job_room;
  assign accept    = in_valid && job_room;
  assign geo_write = cfg_we && (cfg_addr == REG_ROW_LENGTH || cfg_addr == REG_SLICE_ROWS);
  assign fg        = $signed(in_sample) >= $signed(threshold);
  assign wr_data   = {rd_a[0], fg};

  assign rl = cfg_wdata[RL_W-1:0];
  assign sr = cfg_wdata[ROW_W-1:0];

  always_comb begin
    if (rl == '0) begin
      len_m1_next = '0;
    end else if (int'(rl) > MAX_COLS) begin
      len_m1_next = COL_W'(MAX_COLS - 1);
    end else begin
      len_m1_next = COL_W'(rl - RL_W'(1));
    end
  end

  assign row_gt0  = row_count != '0;
  assign last_row = row_count == rows_m1;
  assign col_gt0  = column_count != '0;
  assign col_gt1  = column_count > COL_W'(1);
  assign col_last = column_count == len_m1;

  // Column that the counters will hold after this edge
  always_comb begin
    if (geo_write) begin
      col_next = '0;
    end else if (accept) begin
      col_next = col_last ? '0 : column_count + COL_W'(1);
    end else begin
      col_next = column_count;
    end
  end

  assign addr_b = (col_next == COL_W'(MAX_COLS - 1)) ? '0 : col_next + COL_W'(1);

  // Prefetch this column and the one to its right; forward a same-edge write
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[column_count] <= wr_data;
    end
    rd_a <= (accept && col_next == column_count) ? wr_data : mem[col_next];
    rd_b <= (accept && addr_b == column_count) ? wr_data : mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= '0;
      len_m1       <= COL_W'(LEN_RESET - 1);
      rows_m1      <= ROW_W'(ROWS_RESET - 1);
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (cfg_we && cfg_addr == REG_THRESHOLD) begin
        threshold <= cfg_wdata[SAMPLE_W-1:0];
      end
      if (cfg_we && cfg_addr == REG_ROW_LENGTH) begin
        len_m1 <= len_m1_next;
      end
      if (cfg_we && cfg_addr == REG_SLICE_ROWS) begin
        rows_m1 <= (sr == '0) ? '0 : sr - ROW_W'(1);
      end
      if (geo_write) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (accept) begin
        column_count <= col_next;
        if (col_last) begin
          row_count <= last_row ? '0 : row_count + ROW_W'(1);
        end
      end
    end
  end

  // Left-hand neighbors; stale at column zero, where they are never used
  always_ff @(posedge clk) begin
    if (accept) begin
      up_left   <= rd_a[0];
      cur_left  <= fg;
      cur_left2 <= cur_left;
    end
  end

  assign up_c     = rd_a[0];
  assign upup_c   = rd_a[1];
  assign up_right = rd_b[0];

  always_comb begin
    job      = '0;
    job.row  = row_count;
    job.col  = column_count;
    job.mask = {last_row && col_last, last_row && col_gt0, row_gt0};

    // Voxel one row up
    if (!up_c) begin
      job.lab0 = LABEL_BACKGROUND;
    end else if ((row_count > ROW_W'(1) && !upup_c) || !fg ||
                 (col_gt0 && !up_left) || (!col_last && !up_right)) begin
      job.lab0 = LABEL_SURFACE;
    end else begin
      job.lab0 = LABEL_INTERIOR;
    end

    // Voxel to the left on the last row
    if (!cur_left) begin
      job.lab1 = LABEL_BACKGROUND;
    end else if ((row_gt0 && !up_left) || (col_gt1 && !cur_left2) || !fg) begin
      job.lab1 = LABEL_SURFACE;
    end else begin
      job.lab1 = LABEL_INTERIOR;
    end

    // This voxel, last row and last column
    if (!fg) begin
      job.lab2 = LABEL_BACKGROUND;
    end else if ((row_gt0 && !up_c) || (col_gt0 && !cur_left)) begin
      job.lab2 = LABEL_SURFACE;
    end else begin
      job.lab2 = LABEL_INTERIOR;
    end
  end

  assign job_push = accept && (job.mask != '0);

endmodule

/* design/tsl_queue.sv */
`timescale 1ns / 1ps

module tsl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tsl_pkg::job_t push_job,
  output logic          room,
  input  logic          pop,
  output tsl_pkg::job_t head,
  output logic          head_valid
);
  import tsl_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign room       = count != QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/tsl_back.sv */
`timescale 1ns / 1ps

module tsl_back (
  input  logic                           clk,
  input  logic                           rst,
  input  tsl_pkg::job_t                  head,
  input  logic                           head_valid,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tsl_pkg::OUT_DATA_W-1:0] out_data,
  output logic                           out_last
);
  import tsl_pkg::*;

  logic [2:0]           done;
  logic [2:0]           pend;
  logic [2:0]           pick;
  logic [2:0]           rest;
  logic                 out_free;
  logic                 fire;
  label_t               sel_label;
  logic [ROW_W-1:0]     sel_row;
  logic [COL_W-1:0]     sel_col;
  logic [31:0]          col_wide;
  label_t               label;
  logic [ROW_W-1:0]     pixel_row;
  logic [PIX_COL_W-1:0] pixel_col;

  assign out_free = !out_valid || out_ready;
  assign pend     = head.mask & ~done;
  assign fire     = head_valid && out_free;

  always_comb begin
    if (pend[0]) begin
      pick      = 3'b001;
      sel_label = head.lab0;
      sel_row   = head.row - ROW_W'(1);
      sel_col   = head.col;
    end else if (pend[1]) begin
      pick      = 3'b010;
      sel_label = head.lab1;
      sel_row   = head.row;
      sel_col   = head.col - COL_W'(1);
    end else begin
      pick      = 3'b100;
      sel_label = head.lab2;
      sel_row   = head.row;
      sel_col   = head.col;
    end
  end

  assign rest     = pend & ~pick;
  assign pop      = fire && (rest == '0);
  assign col_wide = 32'(sel_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        done      <= (rest == '0) ? '0 : (done | pick);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      label     <= sel_label;
      pixel_row <= sel_row;
      pixel_col <= col_wide[PIX_COL_W-1:0];
      out_last  <= rest == '0;
    end
  end

  assign out_data = {(OUT_DATA_W - PIX_COL_W - ROW_W - LABEL_W)'(0), pixel_col, pixel_row, label};

endmodule

/* design/threshold_and_surface_label_unit.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tdata[31:0] = sample
// m_*       out  tvalid/tready      tdata = label, pixel_row, pixel_col; tlast = run_last
// cfg_*     in   cfg_we             cfg_addr = register index, cfg_wdata = value
//
// One sample per clock is taken while the queue has room; the classifier labels it in the cycle of its transaction.
// Results leave one per clock from the output register while m_tready is high; on the last slice row an input
// may release up to three labels, and the four-entry job queue buffers the burst.
// Reset (rst, synchronous) clears counters, queue and output valid; no clearing pass.
// A full queue drops s_tready; a stalled m_* side holds its register and fills the queue.
// A label passes through the queue and the output register after the transaction of the
// sample that releases it, normally the sample one row below.
module threshold_and_surface_label_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tsl_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tsl_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tsl_pkg::SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tsl_pkg::OUT_DATA_W-1:0] m_tdata,   // [1:0] label, [17:2] pixel_row,
                                                    // [27:18] pixel_col, [31:28] zero
  output logic                           m_tlast    // run_last
);
  import tsl_pkg::*;

  job_t job;
  job_t head;
  logic q_push;
  logic q_room;
  logic q_pop;
  logic q_valid;

  // Threshold, line buffer and neighborhood classification
  tsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_sample (s_tdata),
    .in_ready  (s_tready),
    .job_push  (q_push),
    .job       (job),
    .job_room  (q_room)
  );

  // Decouple classification from emission
  tsl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (job),
    .room       (q_room),
    .pop        (q_pop),
    .head       (head),
    .head_valid (q_valid)
  );

  // Expand each job into its labels, in raster order
  tsl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

`ifndef SYNTH
  a_label_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("label code out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_room)
    else $error("queue pushed while full");

  a_reset_idle: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
